### design/mmp_pkg.sv
`timescale 1ns / 1ps

package mmp_pkg;

	localparam int DATA_W    = 31;
	localparam int EXP_BITS  = 63;
	localparam int CNT_W     = $clog2(DATA_W);
	localparam int IDX_W     = 3;
	localparam int NUM_LANES = 16;

	typedef logic [DATA_W-1:0] word_t;

	// 2x2 matrix, entry index is 2*row + col
	typedef word_t [3:0] mat_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODULUS = 3'd0,
		REG_BASE_00 = 3'd1,
		REG_BASE_01 = 3'd2,
		REG_BASE_10 = 3'd3,
		REG_BASE_11 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		word_t modulus;
		mat_t  base;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
	} lane_ctl_t;

	localparam word_t MOD_RESET  = word_t'(1000000000);
	localparam mat_t  BASE_RESET = mat_t'{word_t'(0), word_t'(1), word_t'(1), word_t'(1)};

endpackage

### design/mmp_lane.sv
`timescale 1ns / 1ps

module mmp_lane (
	input  logic              clk,
	input  mmp_pkg::lane_ctl_t ctl,
	input  mmp_pkg::word_t    m,
	input  mmp_pkg::word_t    a,
	input  mmp_pkg::word_t    b,
	output mmp_pkg::word_t    r
);
	import mmp_pkg::*;

	word_t               r_q;
	word_t               b_q;
	logic [DATA_W+1:0]   t;
	logic [DATA_W+1:0]   m1;
	logic [DATA_W+1:0]   m2;
	logic [DATA_W+1:0]   r_next;

	// one multiplier bit per cycle while step is high, MSB first: r = (2r + bit*a) mod m, a < m
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + {2'b00, (b_q[DATA_W-1] ? a : '0)};
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		priority if (t >= m2) begin
			r_next = t - m2;
		end else if (t >= m1) begin
			r_next = t - m1;
		end else begin
			r_next = t;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			r_q <= '0;
			b_q <= b;
		end else if (ctl.step) begin
			r_q <= r_next[DATA_W-1:0];
			b_q <= {b_q[DATA_W-2:0], 1'b0};
		end
	end

	assign r = r_q;

endmodule

### design/mmp_cfg_regs.sv
`timescale 1ns / 1ps

module mmp_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [mmp_pkg::IDX_W-1:0]   wr_idx,
	input  mmp_pkg::word_t              wr_data,
	output mmp_pkg::cfg_t               cfg
);
	import mmp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus <= MOD_RESET;
			cfg_q.base    <= BASE_RESET;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_MODULUS: cfg_q.modulus <= wr_data;
				REG_BASE_00: cfg_q.base[0] <= wr_data;
				REG_BASE_01: cfg_q.base[1] <= wr_data;
				REG_BASE_10: cfg_q.base[2] <= wr_data;
				REG_BASE_11: cfg_q.base[3] <= wr_data;
				// drop writes to unmapped indexes
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/modular_matrix_power_2x2_core.sv
`timescale 1ns / 1ps
// 2x2 modular matrix power: returns B^exponent with every entry mod modulus (exponent nonzero).
// Config channel: cfg_valid/cfg_ready with cfg_index (0 modulus, 1..4 base
// entries 00,01,10,11) and cfg_data. cfg_ready is always high; write only
// while busy is low.
// Request channel: a request is taken at a clock edge with start high and
// busy low. The result shows on res_00..res_11 for one cycle with done high.
// The receiver cannot stall; done is a plain strobe.
// Sequence: exponent zero gives the unreduced identity in the cycle after the
// request edge. Otherwise the base is first reduced by a bit-serial pass of
// lanes 0..3; each exponent bit up to the highest set bit then takes a load,
// bit-serial steps of the sixteen modular multiply lanes, and a combine.
// The next request is taken the cycle after done.
// Reset clears the controller and loads the default registers: modulus
// 1000000000 and the Fibonacci base matrix.
module modular_matrix_power_2x2_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [mmp_pkg::EXP_BITS-1:0] exponent,
	output logic                         done,
	output mmp_pkg::word_t               res_00,
	output mmp_pkg::word_t               res_01,
	output mmp_pkg::word_t               res_10,
	output mmp_pkg::word_t               res_11,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mmp_pkg::IDX_W-1:0]    cfg_index,
	input  mmp_pkg::word_t               cfg_data
);
	import mmp_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_PRE      = 7'b0000010,
		S_PRE_DONE = 7'b0000100,
		S_LOAD     = 7'b0001000,
		S_RUN      = 7'b0010000,
		S_COMB     = 7'b0100000,
		S_OUT      = 7'b1000000
	} state_t;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [EXP_BITS-1:0]  e_q;
	word_t                m_q;
	mat_t                 acc_q;
	mat_t                 pw_q;
	mat_t                 acc_new;
	mat_t                 pw_new;
	cfg_t                 cfg;
	word_t                m_start;
	word_t                one;
	logic                 req;
	lane_ctl_t            lane_ctl;
	word_t                lane_a [NUM_LANES];
	word_t                lane_b [NUM_LANES];
	word_t                lane_r [NUM_LANES];

	function automatic word_t mod_add(input word_t x, input word_t y, input word_t m);
		logic [DATA_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[DATA_W-1:0];
	endfunction

	mmp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	assign cfg_ready = 1'b1;
	assign req       = start && (state_q == S_IDLE);
	assign m_start   = (cfg.modulus == '0) ? word_t'(1) : cfg.modulus;
	// identity entry as a reduced multiplicand
	assign one       = (m_q == word_t'(1)) ? '0 : word_t'(1);

	assign lane_ctl.load = req || (state_q == S_LOAD);
	assign lane_ctl.step = (state_q == S_PRE) || (state_q == S_RUN);

	// lanes 0..7 build acc*pw, lanes 8..15 build pw*pw; two lanes per entry.
	// In the base pass lanes 0..3 compute 1*base mod m.
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		localparam int SQ = g / 8;
		localparam int EN = (g % 8) / 2;
		localparam int K  = g % 2;
		localparam int RI = EN / 2;
		localparam int CJ = EN % 2;

		assign lane_a[g] = (state_q == S_PRE) ? one :
			((SQ != 0) ? pw_q[2*RI+K] : acc_q[2*RI+K]);
		assign lane_b[g] = (state_q == S_IDLE) ? cfg.base[g%4] : pw_q[2*K+CJ];

		mmp_lane u_lane (
			.clk (clk),
			.ctl (lane_ctl),
			.m   (m_q),
			.a   (lane_a[g]),
			.b   (lane_b[g]),
			.r   (lane_r[g])
		);
	end

	for (genvar g = 0; g < 4; g++) begin : g_ent
		assign acc_new[g] = mod_add(lane_r[2*g], lane_r[2*g+1], m_q);
		assign pw_new[g]  = mod_add(lane_r[8+2*g], lane_r[9+2*g], m_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= (exponent == '0) ? S_OUT : S_PRE;
					end
				end
				S_PRE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST_STEP) begin
						state_q <= S_PRE_DONE;
					end
				end
				S_PRE_DONE: state_q <= S_LOAD;
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST_STEP) begin
						state_q <= S_COMB;
					end
				end
				S_COMB: state_q <= ((e_q >> 1) == '0) ? S_OUT : S_LOAD;
				S_OUT:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			e_q   <= exponent;
			m_q   <= m_start;
			// unreduced identity, returned as is for exponent zero
			acc_q <= mat_t'{word_t'(1), word_t'(0), word_t'(0), word_t'(1)};
		end else if (state_q == S_PRE_DONE) begin
			pw_q  <= mat_t'{lane_r[3], lane_r[2], lane_r[1], lane_r[0]};
			acc_q <= mat_t'{one, word_t'(0), word_t'(0), one};
		end else if (state_q == S_COMB) begin
			if (e_q[0]) begin
				acc_q <= acc_new;
			end
			pw_q <= pw_new;
			e_q  <= e_q >> 1;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_OUT);
	assign res_00 = acc_q[0];
	assign res_01 = acc_q[1];
	assign res_10 = acc_q[2];
	assign res_11 = acc_q[3];

endmodule

### design/mmp_checker.sv
`timescale 1ns / 1ps

module mmp_port_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [mmp_pkg::EXP_BITS-1:0] exponent,
	input logic                         done,
	input mmp_pkg::word_t               res_00,
	input mmp_pkg::word_t               res_01,
	input mmp_pkg::word_t               res_10,
	input mmp_pkg::word_t               res_11
);
	import mmp_pkg::*;

	// a taken request keeps the block busy
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after a taken request");

	// result strobe only while a request is in flight, then back to idle
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without a request in flight");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block not idle after done");

	// exponent zero returns the plain identity on the next cycle
	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (exponent == '0)) |=>
		(done && (res_00 == word_t'(1)) && (res_01 == '0) &&
		(res_10 == '0) && (res_11 == word_t'(1))))
		else $error("exponent zero did not return the identity");

endmodule

bind modular_matrix_power_2x2_core mmp_port_checker u_mmp_checker (.*);
